FILE: rtl/u8cc_pkg.sv
// Package for the UTF-8 validating code-point counter.
// Holds the default count width, lead-byte decoding and scalar-value checks.
// No dependencies.
`default_nettype none

package u8cc_pkg;

   // Default width of the saturating code-point count
   localparam int COUNT_WIDTH_DEFAULT = 32;

   // Widths of the pending-sequence fields
   localparam int OCTET_W   = 8;
   localparam int LEN_W     = 3;
   localparam int TRAIL_W   = 2;
   localparam int SCALAR_W  = 21;
   localparam int PAYLOAD_W = 6;

   // Sequence lengths
   localparam logic [LEN_W-1:0] SEQ_NONE = 3'd0;
   localparam logic [LEN_W-1:0] SEQ_ONE  = 3'd1;
   localparam logic [LEN_W-1:0] SEQ_TWO  = 3'd2;
   localparam logic [LEN_W-1:0] SEQ_THREE = 3'd3;
   localparam logic [LEN_W-1:0] SEQ_FOUR = 3'd4;

   // Trail bytes look like 10xxxxxx
   localparam logic [1:0] TRAIL_TAG = 2'b10;

   // Scalar-value limits
   localparam logic [SCALAR_W-1:0] MIN_TWO     = 21'h00080;
   localparam logic [SCALAR_W-1:0] MIN_THREE   = 21'h00800;
   localparam logic [SCALAR_W-1:0] MIN_FOUR    = 21'h10000;
   localparam logic [SCALAR_W-1:0] SURR_LO     = 21'h0D800;
   localparam logic [SCALAR_W-1:0] SURR_HI     = 21'h0DFFF;
   localparam logic [SCALAR_W-1:0] SCALAR_MAX  = 21'h10FFFF;

   // Sequence length implied by a byte; one for anything that is not a lead
   function automatic logic [LEN_W-1:0] lead_len(input logic [OCTET_W-1:0] b);
      logic [LEN_W-1:0] len;
      len = SEQ_ONE;
      if (b >= 8'hC2 && b <= 8'hDF) len = SEQ_TWO;
      else if (b >= 8'hE0 && b <= 8'hEF) len = SEQ_THREE;
      else if (b >= 8'hF0 && b <= 8'hF4) len = SEQ_FOUR;
      return len;
   endfunction

   // Payload bits a lead byte contributes
   function automatic logic [SCALAR_W-1:0] lead_bits(input logic [OCTET_W-1:0] b,
                                                    input logic [LEN_W-1:0] len);
      logic [SCALAR_W-1:0] v;
      case (len)
         SEQ_TWO:   v = SCALAR_W'(b & 8'h1F);
         SEQ_THREE: v = SCALAR_W'(b & 8'h0F);
         SEQ_FOUR:  v = SCALAR_W'(b & 8'h07);
         default:   v = SCALAR_W'(b & 8'h7F);
      endcase
      return v;
   endfunction

   // True when a decoded value is shortest-form, not a surrogate, in range
   function automatic logic scalar_ok(input logic [SCALAR_W-1:0] cp,
                                      input logic [LEN_W-1:0] len);
      logic [SCALAR_W-1:0] least;
      logic ok;
      ok = 1'b1;
      case (len)
         SEQ_TWO:   least = MIN_TWO;
         SEQ_THREE: least = MIN_THREE;
         SEQ_FOUR:  least = MIN_FOUR;
         default:   least = '0;
      endcase
      if (len > SEQ_FOUR || cp < least) ok = 1'b0;
      if (cp >= SURR_LO && cp <= SURR_HI) ok = 1'b0;
      if (cp > SCALAR_MAX) ok = 1'b0;
      return ok;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/utf8_validating_codepoint_counter.sv
// Streaming UTF-8 validating code-point counter, top level.
// Depends on u8cc_pkg for lead decoding and scalar-value checks.
// Contains the input register, the sequence tracker and the result register.
`default_nettype none

// Takes one byte per cycle on the req channel and returns one word on the rsp
// channel for each byte marked final: the saturating number of code points in
// the string. A well-formed sequence counts once; every byte of a malformed
// sequence counts once. A NUL stops counting, and a lead whose sequence would
// run past the final byte is counted but nothing after it is. All state clears
// after the final byte. Throughput is one byte per cycle; a byte passes through
// an input register and the per-byte decode/saturating add, and the result word
// of a final byte is registered in the result register that drives rsp.
// A finished result waiting on rsp_ready holds only a following final byte in
// the input register; plain bytes keep flowing until such a byte arrives.
// No clearing pass is needed after reset.
module utf8_validating_codepoint_counter #(
   parameter int COUNT_WIDTH = u8cc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_octet_in,
   input  wire logic        req_final_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_char_count
);

   localparam int LW = u8cc_pkg::LEN_W;
   localparam int TW = u8cc_pkg::TRAIL_W;
   localparam int SW = u8cc_pkg::SCALAR_W;
   localparam int NSLOT = 3;

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   logic [7:0]           s1_octet_ff;
   logic                 s1_final_ff;

   // string state
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                 halted_ff, halted_in;
   logic [TW-1:0]        needed_ff, needed_in;
   logic [TW-1:0]        seen_ff, seen_in;
   logic [LW-1:0]        seq_len_ff, seq_len_in;
   logic [SW-1:0]        partial_ff, partial_in;

   // open lead windows, slot index is age in bytes (0 = newest)
   logic                 win_valid_ff [NSLOT];
   logic                 win_valid_in [NSLOT];
   logic [TW-1:0]        win_left_ff  [NSLOT];
   logic [TW-1:0]        win_left_in  [NSLOT];
   logic [COUNT_WIDTH-1:0] win_count_ff [NSLOT];
   logic [COUNT_WIDTH-1:0] win_count_in [NSLOT];

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_count_ff;

   logic                 advance;
   logic                 trail;
   logic [TW-1:0]        seen_inc;
   logic [SW-1:0]        pv_shift;
   logic [LW-1:0]        len;
   logic [2:0]           bump;
   logic                 new_lead;
   logic [COUNT_WIDTH:0] sum;
   logic [COUNT_WIDTH-1:0] result;

   // handshake: a final byte needs room in the result register
   assign advance   = s1_valid_ff && (!s1_final_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = (advance && s1_final_ff) || (rsp_valid_ff && !rsp_ready);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_count = rsp_count_ff;

   // per-byte decode and sequence tracking
   always_comb begin
      halted_in  = halted_ff;
      needed_in  = needed_ff;
      seen_in    = seen_ff;
      seq_len_in = seq_len_ff;
      partial_in = partial_ff;
      bump       = 3'd0;
      new_lead   = 1'b0;
      trail      = (s1_octet_ff[7:6] == u8cc_pkg::TRAIL_TAG);
      seen_inc   = seen_ff + 2'd1;
      pv_shift   = {partial_ff[SW-7:0], s1_octet_ff[5:0]};
      len        = u8cc_pkg::lead_len(s1_octet_ff);
      if (!halted_ff) begin
         if (seq_len_ff != u8cc_pkg::SEQ_NONE && trail) begin
            partial_in = pv_shift;
            seen_in    = seen_inc;
            if (seen_inc == needed_ff) begin
               if (!u8cc_pkg::scalar_ok(pv_shift, seq_len_ff)) bump = {1'b0, seen_inc};
               needed_in  = '0;
               seen_in    = '0;
               seq_len_in = u8cc_pkg::SEQ_NONE;
               partial_in = '0;
            end
         end else begin
            // a pending sequence broken here counts its consumed bytes
            if (seq_len_ff != u8cc_pkg::SEQ_NONE) bump = {1'b0, seen_ff};
            needed_in  = '0;
            seen_in    = '0;
            seq_len_in = u8cc_pkg::SEQ_NONE;
            partial_in = '0;
            if (s1_octet_ff == 8'h00) begin
               halted_in = 1'b1;
            end else begin
               bump = bump + 3'd1;
               if (len != u8cc_pkg::SEQ_ONE) begin
                  new_lead   = 1'b1;
                  seq_len_in = len;
                  needed_in  = TW'(len - 3'd1);
                  partial_in = u8cc_pkg::lead_bits(s1_octet_ff, len);
               end
            end
         end
      end
   end

   // saturating count update
   always_comb begin
      sum = {1'b0, count_ff} + (COUNT_WIDTH + 1)'(bump);
      count_in = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
   end

   // age the lead windows; a window closes when its remaining bytes run out
   always_comb begin
      win_valid_in[0] = new_lead;
      win_left_in[0]  = TW'(len - 3'd1);
      win_count_in[0] = count_in;
      for (int i = 1; i < NSLOT; i++) begin
         win_valid_in[i] = win_valid_ff[i-1] && (win_left_ff[i-1] != 2'd1);
         win_left_in[i]  = win_left_ff[i-1] - 2'd1;
         win_count_in[i] = win_count_ff[i-1];
      end
   end

   // oldest open window decides the result, else the running count
   always_comb begin
      if (win_valid_in[2])      result = win_count_in[2];
      else if (win_valid_in[1]) result = win_count_in[1];
      else if (win_valid_in[0]) result = win_count_in[0];
      else                      result = count_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         halted_ff    <= 1'b0;
         needed_ff    <= '0;
         seen_ff      <= '0;
         seq_len_ff   <= u8cc_pkg::SEQ_NONE;
         partial_ff   <= '0;
         for (int i = 0; i < NSLOT; i++) begin
            win_valid_ff[i] <= 1'b0;
            win_left_ff[i]  <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            if (s1_final_ff) begin
               // end of string: back to the reset state
               count_ff   <= '0;
               halted_ff  <= 1'b0;
               needed_ff  <= '0;
               seen_ff    <= '0;
               seq_len_ff <= u8cc_pkg::SEQ_NONE;
               partial_ff <= '0;
               for (int i = 0; i < NSLOT; i++) begin
                  win_valid_ff[i] <= 1'b0;
                  win_left_ff[i]  <= '0;
               end
            end else begin
               count_ff   <= count_in;
               halted_ff  <= halted_in;
               needed_ff  <= needed_in;
               seen_ff    <= seen_in;
               seq_len_ff <= seq_len_in;
               partial_ff <= partial_in;
               for (int i = 0; i < NSLOT; i++) begin
                  win_valid_ff[i] <= win_valid_in[i];
                  win_left_ff[i]  <= win_left_in[i];
               end
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_octet_ff <= req_octet_in;
         s1_final_ff <= req_final_byte;
      end
      if (advance) begin
         for (int i = 0; i < NSLOT; i++) win_count_ff[i] <= win_count_in[i];
         if (s1_final_ff) rsp_count_ff <= 32'(result);
      end
   end

`ifndef SYNTHESIS
   // counting stops only between sequences
   a_halt_idle: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> (seq_len_ff == u8cc_pkg::SEQ_NONE))
      else $error("halted with a sequence pending");

   // a pending sequence has fewer trails seen than it needs
   a_seq_shape: assert property (@(posedge clock) disable iff (reset)
      (seq_len_ff != u8cc_pkg::SEQ_NONE) |->
         ((needed_ff == TW'(seq_len_ff - 3'd1)) && (seen_ff < needed_ff)))
      else $error("pending sequence bookkeeping out of step");

   // the oldest window slot can only hold a window with one byte left
   a_old_slot: assert property (@(posedge clock) disable iff (reset)
      win_valid_ff[2] |-> (win_left_ff[2] == 2'd1))
      else $error("window outlived its sequence length");

   // a final byte leaves the tracker cleared
   a_final_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_final_ff) |=>
         (count_ff == '0 && !halted_ff && !win_valid_ff[0] && !win_valid_ff[1]))
      else $error("state not cleared after final byte");
`endif

endmodule

`default_nettype wire
